### hw/rtl/pfd_pkg.sv
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants for the packed repeated field decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int VALUE_W = 64;
    localparam int FIELD_W = 29;
    localparam int COUNT_W = 17;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;

    localparam int DEFAULT_MAX_VARINT_BYTES = 10;
    localparam int DEFAULT_MAX_ELEMENTS     = 65536;
    localparam int QUEUE_DEPTH              = 4;

    localparam int FIXED32_BYTES = 4;
    localparam int FIXED64_BYTES = 8;

    // element_kind codes on the input word
    localparam logic [KIND_W-1:0] KIND_FIXED32  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIXED64  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VARINT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ZIGZAG32 = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ZIGZAG64 = 3'd4;

    // classified kind carried through the queue
    typedef enum logic [2:0] {
        CLS_FIXED32,
        CLS_FIXED64,
        CLS_VARINT,
        CLS_ZIGZAG32,
        CLS_ZIGZAG64,
        CLS_BAD
    } cls_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        cls_t               cls;
        logic [FIELD_W-1:0] field_number;
        logic               last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hw/rtl/pfd_if.sv
// ----------------------------------------------------------------------------
// pfd_if
// Valid/ready channels for input bytes and decoded result words.
// ----------------------------------------------------------------------------
interface pfd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [7:0]                  data_byte;
    logic [pfd_pkg::KIND_W-1:0]  element_kind;
    logic [pfd_pkg::FIELD_W-1:0] field_number;
    logic                        end_of_field;

    modport source (output valid, output data_byte, output element_kind,
                    output field_number, output end_of_field, input ready);
    modport sink   (input valid, input data_byte, input element_kind,
                    input field_number, input end_of_field, output ready);
endinterface

interface pfd_result_if;
    logic                        valid;
    logic                        ready;
    logic [pfd_pkg::VALUE_W-1:0] element_value;
    logic [pfd_pkg::FIELD_W-1:0] result_field;
    logic                        value_valid;
    logic                        decode_error;
    logic                        field_done;
    logic [pfd_pkg::COUNT_W-1:0] element_count;

    modport source (output valid, output element_value, output result_field,
                    output value_valid, output decode_error, output field_done,
                    output element_count, input ready);
    modport sink   (input valid, input element_value, input result_field,
                    input value_valid, input decode_error, input field_done,
                    input element_count, output ready);
endinterface

### hw/rtl/pfd_front.sv
// ----------------------------------------------------------------------------
// pfd_front
// Accepts input bytes, classifies the element kind and pushes them to the
// queue.
// ----------------------------------------------------------------------------
module pfd_front (
    pfd_byte_if.sink              byte_stream,
    input  pfd_pkg::q_status_t    status,
    output logic                  push,
    output pfd_pkg::entry_t       push_entry
);

    pfd_pkg::cls_t cls;

    always_comb
    begin
        unique case (byte_stream.element_kind)
            pfd_pkg::KIND_FIXED32:  cls = pfd_pkg::CLS_FIXED32;
            pfd_pkg::KIND_FIXED64:  cls = pfd_pkg::CLS_FIXED64;
            pfd_pkg::KIND_VARINT:   cls = pfd_pkg::CLS_VARINT;
            pfd_pkg::KIND_ZIGZAG32: cls = pfd_pkg::CLS_ZIGZAG32;
            pfd_pkg::KIND_ZIGZAG64: cls = pfd_pkg::CLS_ZIGZAG64;
            default:                cls = pfd_pkg::CLS_BAD;
        endcase
    end

    assign byte_stream.ready = !status.full;
    assign push              = byte_stream.valid && !status.full;

    assign push_entry.data_byte    = byte_stream.data_byte;
    assign push_entry.cls          = cls;
    assign push_entry.field_number = byte_stream.field_number;
    assign push_entry.last         = byte_stream.end_of_field;

endmodule

### hw/rtl/pfd_queue.sv
// ----------------------------------------------------------------------------
// pfd_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module pfd_queue #(
    parameter int DEPTH = pfd_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pfd_pkg::entry_t     push_entry,
    input  logic                pop,
    output pfd_pkg::entry_t     pop_entry,
    output pfd_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfd_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry    = slots_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

### hw/rtl/pfd_back.sv
// ----------------------------------------------------------------------------
// pfd_back
// Assembles elements from queued bytes, tracks the element count and error
// state, and holds the result word in an output register.
// ----------------------------------------------------------------------------
module pfd_back #(
    parameter int MAX_VARINT_BYTES = pfd_pkg::DEFAULT_MAX_VARINT_BYTES,
    parameter int MAX_ELEMENTS     = pfd_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pfd_pkg::q_status_t  status,
    input  pfd_pkg::entry_t     head,
    output logic                pop,
    pfd_result_if.source        element_stream
);

    localparam int VW  = pfd_pkg::VALUE_W;
    localparam int PW  = pfd_pkg::POS_W;
    localparam int CW  = $clog2(MAX_ELEMENTS + 1);

    logic [VW-1:0] assembly_reg, assembly_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic          failed_reg, failed_next;

    logic                        out_valid_reg, out_valid_next;
    logic [VW-1:0]               value_reg;
    logic [pfd_pkg::FIELD_W-1:0] field_reg;
    logic                        have_reg;
    logic                        error_reg;
    logic                        done_reg;
    logic [pfd_pkg::COUNT_W-1:0] count_out_reg;

    logic [PW-1:0] pos_inc;
    logic [6:0]    pos_x8;
    logic [6:0]    pos_x7;
    logic [VW-1:0] fixed_or;
    logic [VW-1:0] varint_or;
    logic [VW-1:0] merged;
    logic [VW-1:0] value;
    logic          have;
    logic          emit;
    logic          err;

    function automatic logic [VW-1:0] unzig32(input logic [VW-1:0] raw);
        logic [31:0] u;
        logic [31:0] r;
        u = raw[31:0];
        r = (u >> 1) ^ {32{u[0]}};
        return {{32{r[31]}}, r};
    endfunction

    function automatic logic [VW-1:0] unzig64(input logic [VW-1:0] raw);
        return (raw >> 1) ^ {VW{raw[0]}};
    endfunction

    assign pop = !status.empty && (!out_valid_reg || element_stream.ready);

    assign pos_inc   = pos_reg + 1'b1;
    assign pos_x8    = {pos_reg, 3'b000};
    assign pos_x7    = pos_x8 - {3'b000, pos_reg};
    // fixed kinds: 8 bits per byte; varints: 7 bits per byte, low group first
    assign fixed_or  = (pos_reg < PW'(8))
                     ? ({{(VW-8){1'b0}}, head.data_byte} << pos_x8[5:0]) : '0;
    assign varint_or = (pos_reg < PW'(10))
                     ? ({{(VW-7){1'b0}}, head.data_byte[6:0]} << pos_x7[5:0]) : '0;

    always_comb
    begin
        assembly_next = assembly_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        failed_next   = failed_reg;
        have          = 1'b0;
        value         = '0;
        merged        = assembly_reg;

        if (pop && !failed_reg)
        begin
            unique case (head.cls) inside
                pfd_pkg::CLS_FIXED32:
                begin
                    merged        = assembly_reg | fixed_or;
                    assembly_next = merged;
                    pos_next      = pos_inc;
                    have          = (pos_inc >= PW'(pfd_pkg::FIXED32_BYTES));
                    value         = {32'd0, merged[31:0]};
                end
                pfd_pkg::CLS_FIXED64:
                begin
                    merged        = assembly_reg | fixed_or;
                    assembly_next = merged;
                    pos_next      = pos_inc;
                    have          = (pos_inc >= PW'(pfd_pkg::FIXED64_BYTES));
                    value         = merged;
                end
                pfd_pkg::CLS_VARINT, pfd_pkg::CLS_ZIGZAG32, pfd_pkg::CLS_ZIGZAG64:
                begin
                    merged        = assembly_reg | varint_or;
                    assembly_next = merged;
                    pos_next      = pos_inc;
                    have          = !head.data_byte[7];
                    if (head.cls == pfd_pkg::CLS_ZIGZAG32)
                    begin
                        value = unzig32(merged);
                    end
                    else if (head.cls == pfd_pkg::CLS_ZIGZAG64)
                    begin
                        value = unzig64(merged);
                    end
                    else
                    begin
                        value = merged;
                    end
                    if (head.data_byte[7] && pos_inc >= PW'(MAX_VARINT_BYTES))
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase

            if (have)
            begin
                assembly_next = '0;
                pos_next      = '0;
                if (count_reg < CW'(MAX_ELEMENTS))
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        emit = pop && (have || head.last);
        err  = head.last && (failed_next || pos_next != '0);

        if (!out_valid_reg || element_stream.ready)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assembly_reg  <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && head.last)
            begin
                // field ends: back to a clean state for the next one
                assembly_reg <= '0;
                pos_reg      <= '0;
                count_reg    <= '0;
                failed_reg   <= 1'b0;
            end
            else
            begin
                assembly_reg <= assembly_next;
                pos_reg      <= pos_next;
                count_reg    <= count_next;
                failed_reg   <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            value_reg     <= have ? value : '0;
            field_reg     <= head.field_number;
            have_reg      <= have;
            error_reg     <= err;
            done_reg      <= head.last;
            count_out_reg <= pfd_pkg::COUNT_W'(count_next);
        end
    end

    assign element_stream.valid         = out_valid_reg;
    assign element_stream.element_value = value_reg;
    assign element_stream.result_field  = field_reg;
    assign element_stream.value_valid   = have_reg;
    assign element_stream.decode_error  = error_reg;
    assign element_stream.field_done    = done_reg;
    assign element_stream.element_count = count_out_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_VARINT_BYTES))
        else $error("byte position beyond varint limit");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ELEMENTS))
        else $error("element count beyond saturation");

    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        pop && failed_reg |-> !have)
        else $error("element completed after failure");

    a_field_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head.last |=> pos_reg == '0 && count_reg == '0 && !failed_reg)
        else $error("state not cleared at end of field");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !element_stream.ready |-> !pop)
        else $error("pop while result word is stalled");

endmodule

### hw/rtl/packed_field_decoder.sv
// ----------------------------------------------------------------------------
// packed_field_decoder
// Decoder for the payload of one packed repeated field, one byte per word.
// ----------------------------------------------------------------------------
// byte_stream carries one payload byte per word with its element kind,
// field number and an end-of-field flag. element_stream carries a word for
// every completed element and for every last byte of a field; both happen
// on one word when the last byte completes an element.
// An accepted byte is written into the queue, then from the queue head into
// the output register, where its result word can be taken. One byte is
// taken per cycle while the queue has room, set by the single assembly
// register in the back part, which merges one byte per cycle unless stalled.
// A four-word queue separates the front (classify) and back (assemble)
// parts. When element_stream stalls, the held result stays put, the back
// part stops draining the queue and byte_stream.ready drops once the
// queue fills. Bytes that make no result still need a free output register
// to pass.
// Reset clears the queue, the output valid flag and the field state; the
// block is ready for bytes as soon as reset is released.
// ----------------------------------------------------------------------------
module packed_field_decoder #(
    parameter int MAX_VARINT_BYTES = pfd_pkg::DEFAULT_MAX_VARINT_BYTES,
    parameter int MAX_ELEMENTS     = pfd_pkg::DEFAULT_MAX_ELEMENTS
) (
    input  logic          clk,
    input  logic          rst_n,
    pfd_byte_if.sink      byte_stream,
    pfd_result_if.source  element_stream
);

    pfd_pkg::q_status_t status;
    pfd_pkg::entry_t    push_entry;
    pfd_pkg::entry_t    head;
    logic               push;
    logic               pop;

    pfd_front u_front (
        .byte_stream (byte_stream),
        .status      (status),
        .push        (push),
        .push_entry  (push_entry)
    );

    pfd_queue #(
        .DEPTH (pfd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (head),
        .status     (status)
    );

    pfd_back #(
        .MAX_VARINT_BYTES (MAX_VARINT_BYTES),
        .MAX_ELEMENTS     (MAX_ELEMENTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .status         (status),
        .head           (head),
        .pop            (pop),
        .element_stream (element_stream)
    );

endmodule

### tb/sv/pfd_decode_checker.sv
// ----------------------------------------------------------------------------
// pfd_decode_checker
// Watches both channels of the packed field decoder, predicts the result
// word from every accepted byte and compares accepted result words in order.
// ----------------------------------------------------------------------------
module pfd_decode_checker (
    input  logic   clk,
    input  logic   rst_n,
    pfd_byte_if    byte_stream,
    pfd_result_if  element_stream,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [FIELD_W-1:0] field;
        logic               value_valid;
        logic               decode_error;
        logic               field_done;
        logic [COUNT_W-1:0] count;
    } element_word_t;

    element_word_t      expected_words[$];

    // field state of the predictor
    logic [VALUE_W-1:0] partial_value;
    int                 partial_bytes;
    logic [COUNT_W-1:0] field_elements;
    logic               field_failed;

    function automatic logic [VALUE_W-1:0] unzigzag32(input logic [VALUE_W-1:0] raw);
        logic [31:0] r;
        r = (raw[31:0] >> 1) ^ {32{raw[0]}};
        return {{32{r[31]}}, r};
    endfunction

    function automatic logic [VALUE_W-1:0] unzigzag64(input logic [VALUE_W-1:0] raw);
        return (raw >> 1) ^ {VALUE_W{raw[0]}};
    endfunction

    task automatic clear_field();
        partial_value  = '0;
        partial_bytes  = 0;
        field_elements = '0;
        field_failed   = 1'b0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic [KIND_W-1:0] kind,
                               input logic [FIELD_W-1:0] fld, input logic last);
        logic               have;
        logic [VALUE_W-1:0] value;
        int                 need;
        element_word_t      w;
        have  = 1'b0;
        value = '0;
        if (!field_failed)
        begin
            case (kind)
                KIND_FIXED32, KIND_FIXED64:
                begin
                    need = (kind == KIND_FIXED32) ? FIXED32_BYTES : FIXED64_BYTES;
                    if (partial_bytes < FIXED64_BYTES)
                        partial_value |= 64'(b) << (8 * partial_bytes);
                    partial_bytes++;
                    if (partial_bytes >= need)
                    begin
                        value = partial_value;
                        if (kind == KIND_FIXED32)
                            value[63:32] = '0;
                        have = 1'b1;
                    end
                end
                KIND_VARINT, KIND_ZIGZAG32, KIND_ZIGZAG64:
                begin
                    // groups past bit 63 fall off the top of the shift
                    if (partial_bytes < 10)
                        partial_value |= 64'(b[6:0]) << (7 * partial_bytes);
                    partial_bytes++;
                    if (!b[7])
                    begin
                        value = partial_value;
                        if (kind == KIND_ZIGZAG32)
                            value = unzigzag32(value);
                        else if (kind == KIND_ZIGZAG64)
                            value = unzigzag64(value);
                        have = 1'b1;
                    end
                    else if (partial_bytes >= DEFAULT_MAX_VARINT_BYTES)
                        field_failed = 1'b1;
                end
                default:
                    field_failed = 1'b1;
            endcase
            if (have)
            begin
                partial_value = '0;
                partial_bytes = 0;
                if (field_elements < COUNT_W'(DEFAULT_MAX_ELEMENTS))
                    field_elements++;
            end
        end
        if (have || last)
        begin
            w.value        = value;
            w.field        = fld;
            w.value_valid  = have;
            w.decode_error = last && (field_failed || partial_bytes != 0);
            w.field_done   = last;
            w.count        = field_elements;
            expected_words.push_back(w);
        end
        if (last)
            clear_field();
    endtask

    task automatic compare_word();
        element_word_t w;
        if (expected_words.size() == 0)
        begin
            $error("result word with no expected word (field %h)",
                   element_stream.result_field);
            fail_count++;
        end
        else
        begin
            w = expected_words.pop_front();
            if (element_stream.element_value !== w.value)
            begin
                $error("element_value: expected %h, got %h", w.value,
                       element_stream.element_value);
                fail_count++;
            end
            if (element_stream.result_field !== w.field)
            begin
                $error("result_field: expected %h, got %h", w.field,
                       element_stream.result_field);
                fail_count++;
            end
            if (element_stream.value_valid !== w.value_valid)
            begin
                $error("value_valid: expected %b, got %b", w.value_valid,
                       element_stream.value_valid);
                fail_count++;
            end
            if (element_stream.decode_error !== w.decode_error)
            begin
                $error("decode_error: expected %b, got %b", w.decode_error,
                       element_stream.decode_error);
                fail_count++;
            end
            if (element_stream.field_done !== w.field_done)
            begin
                $error("field_done: expected %b, got %b", w.field_done,
                       element_stream.field_done);
                fail_count++;
            end
            if (element_stream.element_count !== w.count)
            begin
                $error("element_count: expected %0d, got %0d", w.count,
                       element_stream.element_count);
                fail_count++;
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_field();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_field();
            expected_words.delete();
        end
        else
        begin
            // a byte accepted now cannot show up on the output at this edge
            if (element_stream.valid && element_stream.ready)
                compare_word();
            if (byte_stream.valid && byte_stream.ready)
                decode_byte(byte_stream.data_byte, byte_stream.element_kind,
                            byte_stream.field_number, byte_stream.end_of_field);
        end
        pending = expected_words.size();
    end

endmodule

### tb/sv/tb_packed_field_decoder.sv
// ----------------------------------------------------------------------------
// tb_packed_field_decoder
// Drives packed field payloads into the decoder: a directed set, then random
// well-formed and broken fields. The checker beside the block predicts and
// compares every word.
// ----------------------------------------------------------------------------
module tb_packed_field_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BAD_LAST  = 3'd7;

    localparam int RANDOM_BYTES = 1320;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;

    logic clk;
    logic rst_n;

    pfd_byte_if   byte_stream ();
    pfd_result_if element_stream ();

    int fail_count;
    int pending;

    bit idling_on;
    bit hold_req;
    int random_sent;

    logic [7:0]        field_bytes[$];
    logic [KIND_W-1:0] field_kinds[$];

    packed_field_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_stream    (byte_stream),
        .element_stream (element_stream)
    );

    pfd_decode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_stream    (byte_stream),
        .element_stream (element_stream),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [KIND_W-1:0] KIND_KIND_PICK();
        return KIND_W'($urandom_range(KIND_FIXED32, KIND_ZIGZAG64));
    endfunction

    function automatic logic [KIND_W-1:0] pick_varint_kind();
        return KIND_W'($urandom_range(KIND_VARINT, KIND_ZIGZAG64));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [KIND_W-1:0] kind,
                             input logic [FIELD_W-1:0] fld, input logic last);
        while (idling_on && $urandom_range(0, 99) < 16)
        begin
            @(negedge clk);
            byte_stream.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        byte_stream.valid        <= 1'b1;
        byte_stream.data_byte    <= b;
        byte_stream.element_kind <= kind;
        byte_stream.field_number <= fld;
        byte_stream.end_of_field <= last;
        do
            @(posedge clk);
        while (!byte_stream.ready);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic [KIND_W-1:0] kind);
        field_bytes.push_back(b);
        field_kinds.push_back(kind);
    endtask

    task automatic add_fixed(input logic [KIND_W-1:0] kind, input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom), kind);
    endtask

    // unterminated runs keep bit 7 set on every byte
    task automatic add_varint(input logic [KIND_W-1:0] kind, input int len,
                              input bit terminated);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b    = 8'($urandom);
            b[7] = (i < len - 1) || !terminated;
            push_byte(b, kind);
        end
    endtask

    task automatic add_element(input logic [KIND_W-1:0] kind);
        int len;
        if (kind == KIND_FIXED32)
            add_fixed(kind, FIXED32_BYTES);
        else if (kind == KIND_FIXED64)
            add_fixed(kind, FIXED64_BYTES);
        else
        begin
            len = ($urandom_range(0, 3) == 0) ?
                  $urandom_range(1, DEFAULT_MAX_VARINT_BYTES) : $urandom_range(1, 3);
            add_varint(kind, len, 1'b1);
        end
    endtask

    // partial element of a random kind, left open
    task automatic add_partial();
        logic [KIND_W-1:0] kind;
        kind = KIND_KIND_PICK();
        if (kind == KIND_FIXED32)
            add_fixed(kind, $urandom_range(1, FIXED32_BYTES - 1));
        else if (kind == KIND_FIXED64)
            add_fixed(kind, $urandom_range(1, FIXED64_BYTES - 1));
        else
            add_varint(kind, $urandom_range(1, DEFAULT_MAX_VARINT_BYTES - 1), 1'b0);
    endtask

    // sends the collected bytes as one field, end_of_field on the last one
    task automatic send_field(input logic [FIELD_W-1:0] fld);
        int n;
        if (field_bytes.size() == 0)
            push_byte(8'($urandom), KIND_W'($urandom));
        n = field_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(field_bytes[i], field_kinds[i], fld, i == n - 1);
        if (random_sent >= 0)
            random_sent += n;
        field_bytes.delete();
        field_kinds.delete();
    endtask

    task automatic random_field();
        logic [KIND_W-1:0] kind;
        int                n;
        kind = KIND_KIND_PICK();
        n    = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            add_element(($urandom_range(0, 19) == 0) ? KIND_KIND_PICK() : kind);
        if ($urandom_range(0, 99) < 20)
        begin
            case ($urandom_range(0, 4))
                0: add_partial();
                1:
                begin
                    add_varint(pick_varint_kind(), DEFAULT_MAX_VARINT_BYTES, 1'b0);
                    add_element(kind);
                end
                2:
                begin
                    push_byte(8'($urandom),
                              KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST)));
                    add_element(kind);
                end
                3:
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        push_byte(8'($urandom), KIND_W'($urandom));
                default:
                begin
                    // element switches kind halfway
                    add_partial();
                    add_element(KIND_KIND_PICK());
                end
            endcase
        end
        send_field(pick_field());
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        element_stream.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                element_stream.ready <= 1'b0;
            end
            else
                element_stream.ready <= !(idling_on && $urandom_range(0, 99) < 16);
        end
    end

    initial
    begin
        bit         held;
        held        = 1'b0;
        idling_on   = 1'b1;
        hold_req    = 1'b0;
        random_sent = -1;
        rst_n                    = 1'b0;
        byte_stream.valid        = 1'b0;
        byte_stream.data_byte    = '0;
        byte_stream.element_kind = KIND_FIXED32;
        byte_stream.field_number = '0;
        byte_stream.end_of_field = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all-ones fixed32 on the largest field number, done on the same word
        for (int i = 0; i < FIXED32_BYTES; i++)
            push_byte(8'hFF, KIND_FIXED32);
        send_field('1);
        // fixed64 with top and bottom bytes at their extremes
        push_byte(8'h00, KIND_FIXED64);
        for (int i = 1; i < FIXED64_BYTES - 1; i++)
            push_byte(8'(8'h11 * i), KIND_FIXED64);
        push_byte(8'hFF, KIND_FIXED64);
        send_field('0);
        // zigzag32 of -1, zigzag64 of -64, then plain zero
        push_byte(8'h01, KIND_ZIGZAG32);
        push_byte(8'h7F, KIND_ZIGZAG64);
        push_byte(8'h00, KIND_VARINT);
        send_field(29'h0AAA_AAAA);
        // payload ends mid-element
        push_byte(8'hAA, KIND_FIXED32);
        push_byte(8'h55, KIND_FIXED32);
        send_field(29'h1555_5555);
        // bad kind, then bytes that are ignored until the end
        push_byte(8'h00, KIND_BAD_LAST);
        push_byte(8'h00, KIND_VARINT);
        push_byte(8'hFF, KIND_FIXED32);
        send_field(29'h0123_4567);
        // varint byte left open, then fixed32 bytes finish the element
        push_byte(8'h80, KIND_VARINT);
        push_byte(8'h11, KIND_FIXED32);
        push_byte(8'h22, KIND_FIXED32);
        push_byte(8'h33, KIND_FIXED32);
        send_field(29'h1FED_CBA9);

        random_sent = 0;
        while (random_sent < RANDOM_BYTES)
        begin
            if (!held && random_sent >= 300)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            idling_on = !(random_sent >= 600 && random_sent < 900);
            random_field();
        end
        random_sent = -1;

        @(negedge clk);
        byte_stream.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #6ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
